// File: rtl/core/utf8_to_utf16_decoder_unit_assert.svh
// Assertion macros for the UTF-8 to UTF-16 decoder unit.
// Used by u8u16_decode under rtl/core; needs clk_i and rst_ni in scope.
`ifndef UTF8_TO_UTF16_DECODER_UNIT_ASSERT_SVH
`define UTF8_TO_UTF16_DECODER_UNIT_ASSERT_SVH

// Check a property on every clock edge outside reset.
`define U8U16_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Check that a condition implies a consequence in the next cycle.
`define U8U16_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/core/u8u16_pkg.sv
// Shared types and constants for the UTF-8 to UTF-16 decoder unit.
// No dependencies; used by all decoder modules.
package u8u16_pkg;

  // Lead byte classification
  localparam logic [7:0] ASCII_MASK = 8'h80;
  localparam logic [7:0] LEAD2_MASK = 8'hE0;
  localparam logic [7:0] LEAD2_CODE = 8'hC0;

  // Continuation bytes still expected
  localparam logic [1:0] PEND_NONE = 2'd0;
  localparam logic [1:0] PEND_ONE  = 2'd1;
  localparam logic [1:0] PEND_TWO  = 2'd2;

  typedef struct packed {
    logic [7:0] byte_value;
    logic       end_marker;
  } in_item_t;

  typedef struct packed {
    logic [15:0] code_unit;
    logic        end_record;
    logic [7:0]  char_total;
    logic [7:0]  length_prefix;
    logic        overflowed;
  } out_item_t;

endpackage

// File: rtl/core/u8u16_stream_if.sv
// Valid/ready channel interfaces for the decoder byte input and unit output.
// Depends on nothing but plain logic types.
interface u8u16_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] byte_value;
  logic       end_marker;

  modport source (output valid, output byte_value, output end_marker, input ready);
  modport sink   (input valid, input byte_value, input end_marker, output ready);
endinterface

interface u8u16_unit_if;
  logic        valid;
  logic        ready;
  logic [15:0] code_unit;
  logic        end_record;
  logic [7:0]  char_total;
  logic [7:0]  length_prefix;
  logic        overflowed;

  modport source (output valid, output code_unit, output end_record, output char_total,
                  output length_prefix, output overflowed, input ready);
  modport sink   (input valid, input code_unit, input end_record, input char_total,
                  input length_prefix, input overflowed, output ready);
endinterface

// File: rtl/core/utf8_to_utf16_decoder_unit.sv
// Top level of the UTF-8 to UTF-16 decoder unit.
// Depends on u8u16_pkg, u8u16_stream_if and the u8u16 stage modules.
//
// Usage:
//   in_ch_i takes one UTF-8 byte per transaction (byte_value), or an end
//   transaction (end_marker = 1) that closes the string. out_ch_o gives one
//   code unit per complete character, and one end record per string with the
//   character total, the length prefix and the overflow flag.
//   The byte is accepted into the input register, decoded combinationally,
//   and loaded into the result register, which drives out_ch_o.valid.
//   Throughput: one byte per cycle while the receiver does not stall.
//   Bytes that finish no character, and characters past MAX_CHARS, give no
//   result; a truncated last character is dropped at the end transaction.
//   Reset clears the string state and both stage valids; the block accepts
//   on the first cycle after reset.
//   When the receiver stalls, the result register holds its unit, one more
//   byte is held in the input register, and then in_ch_i.ready drops.
module utf8_to_utf16_decoder_unit #(
  parameter int unsigned MAX_CHARS = 254
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  u8u16_byte_if.sink      in_ch_i,
  u8u16_unit_if.source    out_ch_o
);

  u8u16_pkg::in_item_t  in_item;
  u8u16_pkg::in_item_t  stage_item;
  u8u16_pkg::out_item_t res_item;
  u8u16_pkg::out_item_t out_item;
  logic                 stage_valid;
  logic                 res_valid;
  logic                 out_free;
  logic                 in_ready;
  logic                 out_valid;

  assign in_item.byte_value = in_ch_i.byte_value;
  assign in_item.end_marker = in_ch_i.end_marker;
  assign in_ch_i.ready      = in_ready;

  u8u16_in_stage u_in_stage (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (in_ch_i.valid),
    .item_i  (in_item),
    .ready_o (in_ready),
    .take_i  (out_free),
    .valid_o (stage_valid),
    .item_o  (stage_item)
  );

  u8u16_decode #(
    .MAX_CHARS (MAX_CHARS)
  ) u_decode (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .valid_i     (stage_valid),
    .item_i      (stage_item),
    .take_i      (out_free),
    .res_valid_o (res_valid),
    .res_o       (res_item)
  );

  u8u16_out_stage u_out_stage (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .res_valid_i (res_valid),
    .res_i       (res_item),
    .free_o      (out_free),
    .valid_o     (out_valid),
    .ready_i     (out_ch_o.ready),
    .item_o      (out_item)
  );

  // Drive the output channel
  assign out_ch_o.valid         = out_valid;
  assign out_ch_o.code_unit     = out_item.code_unit;
  assign out_ch_o.end_record    = out_item.end_record;
  assign out_ch_o.char_total    = out_item.char_total;
  assign out_ch_o.length_prefix = out_item.length_prefix;
  assign out_ch_o.overflowed    = out_item.overflowed;

endmodule

// File: rtl/core/u8u16_in_stage.sv
// Input register of the decoder: captures one byte transaction per cycle while the held item moves on.
// Depends on u8u16_pkg for the input item type.
module u8u16_in_stage (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 valid_i,
  input  u8u16_pkg::in_item_t  item_i,
  output logic                 ready_o,
  input  logic                 take_i,
  output logic                 valid_o,
  output u8u16_pkg::in_item_t  item_o
);

  logic                valid_q, valid_d;
  u8u16_pkg::in_item_t item_q;

  // Accept when empty or when the held item moves on this cycle
  assign ready_o = !valid_q || take_i;
  assign valid_d = ready_o ? valid_i : valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Load payload on a new transaction
  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      item_q <= item_i;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule

// File: rtl/core/u8u16_decode.sv
// Decoder core: string state and the combinational UTF-8 step.
// Depends on u8u16_pkg and utf8_to_utf16_decoder_unit_assert.svh.
`include "utf8_to_utf16_decoder_unit_assert.svh"

module u8u16_decode #(
  parameter int unsigned MAX_CHARS = 254
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  valid_i,
  input  u8u16_pkg::in_item_t   item_i,
  input  logic                  take_i,
  output logic                  res_valid_o,
  output u8u16_pkg::out_item_t  res_o
);

  localparam logic [7:0] MaxCnt = 8'(MAX_CHARS);

  logic [15:0] part_q, part_d;
  logic [1:0]  pend_q, pend_d;
  logic [7:0]  cnt_q, cnt_d;
  logic        ovf_q, ovf_d;

  logic        adv;
  logic        done;
  logic        res_valid;
  logic [15:0] unit;
  logic [7:0]  b;
  logic        st_clear;
  u8u16_pkg::out_item_t res;

  assign adv = valid_i && take_i;
  assign b   = item_i.byte_value;

  // Decode one byte or close the string
  always_comb begin
    part_d    = part_q;
    pend_d    = pend_q;
    cnt_d     = cnt_q;
    ovf_d     = ovf_q;
    done      = 1'b0;
    unit      = '0;
    res       = '0;
    res_valid = 1'b0;
    if (item_i.end_marker) begin
      res.end_record    = 1'b1;
      res.char_total    = cnt_q;
      res.length_prefix = (cnt_q == 8'd0) ? 8'd0 : cnt_q + 8'd1;
      res.overflowed    = ovf_q;
      res_valid         = 1'b1;
      part_d            = '0;
      pend_d            = u8u16_pkg::PEND_NONE;
      cnt_d             = '0;
      ovf_d             = 1'b0;
    end else begin
      case (pend_q)
        u8u16_pkg::PEND_NONE: begin
          if ((b & u8u16_pkg::ASCII_MASK) == 8'h00) begin
            unit = {8'h00, b};
            done = 1'b1;
          end else if ((b & u8u16_pkg::LEAD2_MASK) == u8u16_pkg::LEAD2_CODE) begin
            part_d = {5'b0, b[4:0], 6'b0};
            pend_d = u8u16_pkg::PEND_ONE;
          end else begin
            part_d = {b[3:0], 12'b0};
            pend_d = u8u16_pkg::PEND_TWO;
          end
        end
        u8u16_pkg::PEND_ONE: begin
          unit   = part_q | {10'b0, b[5:0]};
          part_d = '0;
          pend_d = u8u16_pkg::PEND_NONE;
          done   = 1'b1;
        end
        default: begin
          part_d = part_q | {4'b0, b[5:0], 6'b0};
          pend_d = u8u16_pkg::PEND_ONE;
        end
      endcase
      // Drop characters past the limit, count the rest
      if (done) begin
        if (cnt_q >= MaxCnt) begin
          ovf_d = 1'b1;
        end else begin
          cnt_d         = cnt_q + 8'd1;
          res.code_unit = unit;
          res_valid     = 1'b1;
        end
      end
    end
  end

  // Advance string state once per consumed transaction
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      part_q <= '0;
      pend_q <= u8u16_pkg::PEND_NONE;
      cnt_q  <= '0;
      ovf_q  <= 1'b0;
    end else if (adv) begin
      part_q <= part_d;
      pend_q <= pend_d;
      cnt_q  <= cnt_d;
      ovf_q  <= ovf_d;
    end
  end

  assign res_valid_o = adv && res_valid;
  assign res_o       = res;

  // String state back at its idle value
  assign st_clear = (cnt_q == 8'd0) && (pend_q == u8u16_pkg::PEND_NONE) && !ovf_q;

  `U8U16_ASSERT(a_pend_legal, pend_q <= u8u16_pkg::PEND_TWO, "pending count out of range")
  `U8U16_ASSERT(a_cnt_limit, cnt_q <= MaxCnt, "character count past limit")
  `U8U16_ASSERT(a_ovf_at_limit, !ovf_q || (cnt_q == MaxCnt), "overflow without full count")
  `U8U16_ASSERT_NEXT(a_end_clears, adv && item_i.end_marker, st_clear, "state not cleared")

endmodule

// File: rtl/core/u8u16_out_stage.sv
// Result register of the decoder: holds a result until the receiver takes it.
// Depends on u8u16_pkg for the result item type.
module u8u16_out_stage (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  res_valid_i,
  input  u8u16_pkg::out_item_t  res_i,
  output logic                  free_o,
  output logic                  valid_o,
  input  logic                  ready_i,
  output u8u16_pkg::out_item_t  item_o
);

  logic                 valid_q, valid_d;
  u8u16_pkg::out_item_t item_q;

  // Free when empty or when the receiver takes the held result
  assign free_o  = !valid_q || ready_i;
  assign valid_d = free_o ? res_valid_i : valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Capture a new result
  always_ff @(posedge clk_i) begin
    if (res_valid_i && free_o) begin
      item_q <= res_i;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule
